// ===== sv/rgbhsv_pkg.sv =====
`timescale 1ns / 1ps

package rgbhsv_pkg;

  // Hue arithmetic constants (degrees and sector bases)
  localparam int unsigned HUE_SCALE    = 60;
  localparam int unsigned TURN_DEG     = 360;
  localparam int unsigned SECTOR_RED   = 3;
  localparam int unsigned SECTOR_GREEN = 5;
  localparam int unsigned SECTOR_BLUE  = 1;

  // Fixed integer part of the hue word: 360 < 2**9
  localparam int unsigned HUE_INT_BITS = 9;

  // Which channel holds the minimum
  typedef enum logic [1:0] {
    MIN_RED,
    MIN_GREEN,
    MIN_BLUE
  } min_sel_e;

  // Control that travels with each item down the pipe
  typedef struct packed {
    logic valid;
    logic grey;
  } ctl_t;

endpackage

// ===== sv/rgbhsv_front.sv =====
`timescale 1ns / 1ps

// Three-stage front end: max/min search, hue numerator and saturation dividend, then scaled hue dividend.
module rgbhsv_front #(
  parameter int unsigned CHANNEL_BITS      = 8,
  parameter int unsigned HUE_FRACTION_BITS = 6
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  input  logic [CHANNEL_BITS-1:0]                red_i,
  input  logic [CHANNEL_BITS-1:0]                green_i,
  input  logic [CHANNEL_BITS-1:0]                blue_i,
  output rgbhsv_pkg::ctl_t                       ctl_o,
  output logic [CHANNEL_BITS-1:0]                d_o,
  output logic [CHANNEL_BITS-1:0]                mx_o,
  output logic [CHANNEL_BITS+rgbhsv_pkg::HUE_INT_BITS+HUE_FRACTION_BITS-1:0] hue_work_o,
  output logic [2*CHANNEL_BITS-1:0]              sat_work_o
);
  import rgbhsv_pkg::*;

  localparam int unsigned C  = CHANNEL_BITS;
  localparam int unsigned HW = HUE_INT_BITS + HUE_FRACTION_BITS;
  localparam int unsigned NB = C + 3;   // hue numerator, up to 6*d
  localparam int unsigned NW = C + HW;  // scaled hue dividend

  // ---------------- stage 1: extremes and sector choice ----------------
  logic [C-1:0] mx1_d, mn1_d, p1_d, m1_d;
  min_sel_e     sel1_d;
  ctl_t         ctl1_q;
  logic [C-1:0] mx1_q, d1_q, p1_q, m1_q;
  min_sel_e     sel1_q;

  always_comb begin
    mx1_d = red_i;
    mn1_d = red_i;
    if (green_i > mx1_d) mx1_d = green_i;
    if (blue_i  > mx1_d) mx1_d = blue_i;
    if (green_i < mn1_d) mn1_d = green_i;
    if (blue_i  < mn1_d) mn1_d = blue_i;
    // minimum ties resolve red, then green, then blue
    if (red_i == mn1_d) begin
      sel1_d = MIN_RED;
      p1_d   = blue_i;
      m1_d   = green_i;
    end else if (green_i == mn1_d) begin
      sel1_d = MIN_GREEN;
      p1_d   = red_i;
      m1_d   = blue_i;
    end else begin
      sel1_d = MIN_BLUE;
      p1_d   = green_i;
      m1_d   = red_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
    end else begin
      ctl1_q.valid <= valid_i;
      ctl1_q.grey  <= (mx1_d == mn1_d);
    end
  end

  always_ff @(posedge clk_i) begin
    mx1_q  <= mx1_d;
    d1_q   <= mx1_d - mn1_d;
    sel1_q <= sel1_d;
    p1_q   <= p1_d;
    m1_q   <= m1_d;
  end

  // ---------------- stage 2: hue numerator, saturation dividend ----------------
  logic [NB-1:0]    base2;
  logic [NB-1:0]    n2_d;
  ctl_t             ctl2_q;
  logic [NB-1:0]    n2_q;
  logic [C-1:0]     d2_q, mx2_q;
  logic [2*C-1:0]   sn2_q;

  always_comb begin
    case (sel1_q)
      MIN_RED:   base2 = NB'(SECTOR_RED);
      MIN_GREEN: base2 = NB'(SECTOR_GREEN);
      MIN_BLUE:  base2 = NB'(SECTOR_BLUE);
      default:   base2 = '0;
    endcase
    // base*d + p - m, never negative
    n2_d = NB'(base2 * NB'(d1_q)) + NB'(p1_q) - NB'(m1_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl2_q <= '0;
    end else begin
      ctl2_q <= ctl1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    n2_q  <= n2_d;
    d2_q  <= d1_q;
    mx2_q <= mx1_q;
    // (2^C - 1) * d
    sn2_q <= {d1_q, {C{1'b0}}} - (2*C)'(d1_q);
  end

  // ---------------- stage 3: hue dividend n * 60 * 2^F ----------------
  ctl_t           ctl3_q;
  logic [NW-1:0]  hn3_q;
  logic [C-1:0]   d3_q, mx3_q;
  logic [2*C-1:0] sn3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl3_q <= '0;
    end else begin
      ctl3_q <= ctl2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    hn3_q <= NW'(NW'(n2_q) * NW'(HUE_SCALE)) << HUE_FRACTION_BITS;
    d3_q  <= d2_q;
    mx3_q <= mx2_q;
    sn3_q <= sn2_q;
  end

  assign ctl_o      = ctl3_q;
  assign d_o        = d3_q;
  assign mx_o       = mx3_q;
  assign hue_work_o = hn3_q;
  assign sat_work_o = sn3_q;

endmodule

// ===== sv/rgbhsv_div_step.sv =====
`timescale 1ns / 1ps

// One registered restoring-division step for both dividers.
// Work word = {partial remainder, dividend bits / quotient bits}.
module rgbhsv_div_step #(
  parameter int unsigned CHANNEL_BITS = 8,
  parameter int unsigned HUE_Q_BITS   = 15,
  parameter bit          HUE_ON       = 1'b1,
  parameter bit          SAT_ON       = 1'b1
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  rgbhsv_pkg::ctl_t                     ctl_i,
  input  logic [CHANNEL_BITS-1:0]              d_i,
  input  logic [CHANNEL_BITS-1:0]              mx_i,
  input  logic [CHANNEL_BITS+HUE_Q_BITS-1:0]   hue_work_i,
  input  logic [2*CHANNEL_BITS-1:0]            sat_work_i,
  output rgbhsv_pkg::ctl_t                     ctl_o,
  output logic [CHANNEL_BITS-1:0]              d_o,
  output logic [CHANNEL_BITS-1:0]              mx_o,
  output logic [CHANNEL_BITS+HUE_Q_BITS-1:0]   hue_work_o,
  output logic [2*CHANNEL_BITS-1:0]            sat_work_o
);
  import rgbhsv_pkg::*;

  localparam int unsigned C  = CHANNEL_BITS;
  localparam int unsigned HQ = HUE_Q_BITS;

  logic [C:0]        hue_t, hue_r, sat_t, sat_r;
  logic              hue_ge, sat_ge;
  logic [C+HQ-1:0]   hue_work_d;
  logic [2*C-1:0]    sat_work_d;
  ctl_t              ctl_q;
  logic [C-1:0]      d_q, mx_q;
  logic [C+HQ-1:0]   hue_work_q;
  logic [2*C-1:0]    sat_work_q;

  // Hue: divide by d
  always_comb begin
    hue_t  = {hue_work_i[C+HQ-1:HQ], hue_work_i[HQ-1]};
    hue_ge = (hue_t >= {1'b0, d_i});
    hue_r  = hue_ge ? (hue_t - {1'b0, d_i}) : hue_t;
    if (HUE_ON) begin
      hue_work_d = {hue_r[C-1:0], hue_work_i[HQ-2:0], hue_ge};
    end else begin
      hue_work_d = hue_work_i;
    end
  end

  // Saturation: divide by max
  always_comb begin
    sat_t  = {sat_work_i[2*C-1:C], sat_work_i[C-1]};
    sat_ge = (sat_t >= {1'b0, mx_i});
    sat_r  = sat_ge ? (sat_t - {1'b0, mx_i}) : sat_t;
    if (SAT_ON) begin
      sat_work_d = {sat_r[C-1:0], sat_work_i[C-2:0], sat_ge};
    end else begin
      sat_work_d = sat_work_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q        <= d_i;
    mx_q       <= mx_i;
    hue_work_q <= hue_work_d;
    sat_work_q <= sat_work_d;
  end

  assign ctl_o      = ctl_q;
  assign d_o        = d_q;
  assign mx_o       = mx_q;
  assign hue_work_o = hue_work_q;
  assign sat_work_o = sat_work_q;

endmodule

// ===== sv/rgb_to_hsv_pixel_core.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake           Payload
// ------------------------------------------------------------------------
// pixel in  in         start, busy         red_in_i, green_in_i, blue_in_i
// HSV out   out        done_o (1 cycle)    hue_out_o, sat_out_o, value_out_o
//
// One pixel per clock; busy stays low. The pipeline holds three front
// stages, D = max(9 + HUE_FRACTION_BITS, CHANNEL_BITS) restoring-division
// steps (one quotient bit each) and an output register. The division chain
// sets the depth. Reset clears the valid and grey control bits only.
// The receiver cannot stall; each result shows for one cycle.
module rgb_to_hsv_pixel_core #(
  parameter int unsigned CHANNEL_BITS      = 8,
  parameter int unsigned HUE_FRACTION_BITS = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [CHANNEL_BITS-1:0]       red_in_i,
  input  logic [CHANNEL_BITS-1:0]       green_in_i,
  input  logic [CHANNEL_BITS-1:0]       blue_in_i,
  output logic                          done_o,
  output logic [rgbhsv_pkg::HUE_INT_BITS+HUE_FRACTION_BITS-1:0] hue_out_o,
  output logic [CHANNEL_BITS-1:0]       sat_out_o,
  output logic [CHANNEL_BITS-1:0]       value_out_o
);
  import rgbhsv_pkg::*;

  localparam int unsigned C     = CHANNEL_BITS;
  localparam int unsigned HW    = HUE_INT_BITS + HUE_FRACTION_BITS;
  localparam int unsigned DEPTH = (HW > C) ? HW : C;
  localparam logic [HW-1:0] FULL_TURN = HW'(TURN_DEG) << HUE_FRACTION_BITS;

  ctl_t             ctl_s      [DEPTH+1];
  logic [C-1:0]     d_s        [DEPTH+1];
  logic [C-1:0]     mx_s       [DEPTH+1];
  logic [C+HW-1:0]  hue_work_s [DEPTH+1];
  logic [2*C-1:0]   sat_work_s [DEPTH+1];

  assign busy = 1'b0;

  // Extremes, numerators and dividends
  rgbhsv_front #(
    .CHANNEL_BITS      (CHANNEL_BITS),
    .HUE_FRACTION_BITS (HUE_FRACTION_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (start & ~busy),
    .red_i      (red_in_i),
    .green_i    (green_in_i),
    .blue_i     (blue_in_i),
    .ctl_o      (ctl_s[0]),
    .d_o        (d_s[0]),
    .mx_o       (mx_s[0]),
    .hue_work_o (hue_work_s[0]),
    .sat_work_o (sat_work_s[0])
  );

  // Division chain; the shorter divider idles in the leading steps
  for (genvar i = 0; i < DEPTH; i++) begin : g_step
    rgbhsv_div_step #(
      .CHANNEL_BITS (CHANNEL_BITS),
      .HUE_Q_BITS   (HW),
      .HUE_ON       (i >= DEPTH - HW),
      .SAT_ON       (i >= DEPTH - C)
    ) u_step (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl_s[i]),
      .d_i        (d_s[i]),
      .mx_i       (mx_s[i]),
      .hue_work_i (hue_work_s[i]),
      .sat_work_i (sat_work_s[i]),
      .ctl_o      (ctl_s[i+1]),
      .d_o        (d_s[i+1]),
      .mx_o       (mx_s[i+1]),
      .hue_work_o (hue_work_s[i+1]),
      .sat_work_o (sat_work_s[i+1])
    );
  end

  // Output stage: full-turn wrap and grey override
  logic [HW-1:0] hue_raw, hue_d;
  logic          done_q;
  logic [HW-1:0] hue_q;
  logic [C-1:0]  sat_q, value_q;

  always_comb begin
    hue_raw = hue_work_s[DEPTH][HW-1:0];
    hue_d   = (hue_raw >= FULL_TURN) ? (hue_raw - FULL_TURN) : hue_raw;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctl_s[DEPTH].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    hue_q   <= ctl_s[DEPTH].grey ? '0 : hue_d;
    sat_q   <= ctl_s[DEPTH].grey ? '0 : sat_work_s[DEPTH][C-1:0];
    value_q <= mx_s[DEPTH];
  end

  assign done_o      = done_q;
  assign hue_out_o   = hue_q;
  assign sat_out_o   = sat_q;
  assign value_out_o = value_q;

endmodule

// ===== sv/rgbhsv_checker.sv =====
`timescale 1ns / 1ps

module rgbhsv_checker #(
  parameter int unsigned CHANNEL_BITS      = 8,
  parameter int unsigned HUE_FRACTION_BITS = 6
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic                          done_o,
  input logic [rgbhsv_pkg::HUE_INT_BITS+HUE_FRACTION_BITS-1:0] hue_out_o,
  input logic [CHANNEL_BITS-1:0]       sat_out_o,
  input logic [CHANNEL_BITS-1:0]       value_out_o
);
  import rgbhsv_pkg::*;

  localparam int unsigned HW    = HUE_INT_BITS + HUE_FRACTION_BITS;
  localparam int unsigned DEPTH = (HW > CHANNEL_BITS) ? HW : CHANNEL_BITS;
  localparam int unsigned LAT   = DEPTH + 4;
  localparam logic [HW-1:0] FULL_TURN = HW'(TURN_DEG) << HUE_FRACTION_BITS;

  // Every accepted item comes out after the fixed latency
  a_accept_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LAT done_o)
    else $error("accepted item did not produce a result");

  // No result without an item accepted the latency earlier
  a_done_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy && rst_ni, LAT))
    else $error("result without a matching item");

  // Hue wraps below a full turn
  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (hue_out_o < FULL_TURN))
    else $error("hue reached a full turn");

  // Zero saturation only for grey pixels, whose hue is zero
  a_grey_hue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (sat_out_o == '0)) |-> (hue_out_o == '0))
    else $error("grey pixel with non-zero hue");

  // Black is grey
  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (value_out_o == '0)) |-> (sat_out_o == '0))
    else $error("black pixel with non-zero saturation");

endmodule

bind rgb_to_hsv_pixel_core rgbhsv_checker #(
  .CHANNEL_BITS      (CHANNEL_BITS),
  .HUE_FRACTION_BITS (HUE_FRACTION_BITS)
) u_rgbhsv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .done_o      (done_o),
  .hue_out_o   (hue_out_o),
  .sat_out_o   (sat_out_o),
  .value_out_o (value_out_o)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import rgbhsv_pkg::*;

  localparam int unsigned CHANNEL_BITS      = 8;
  localparam int unsigned HUE_FRACTION_BITS = 6;
  localparam int unsigned HUE_W   = HUE_INT_BITS + HUE_FRACTION_BITS;
  localparam int unsigned DIV_W   = (HUE_W > CHANNEL_BITS) ? HUE_W : CHANNEL_BITS;
  localparam int unsigned LATENCY = DIV_W + 4;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RANDOM_ITEMS = 1430;
  localparam logic [CHANNEL_BITS-1:0] CH_MAX = {CHANNEL_BITS{1'b1}};

  typedef logic [CHANNEL_BITS-1:0] chan_t;

  typedef struct packed {
    logic [HUE_W-1:0]        hue;
    logic [CHANNEL_BITS-1:0] sat;
    logic [CHANNEL_BITS-1:0] value_ch;
  } hsv_t;

  logic  clk_i;
  logic  rst_ni;
  logic  start;
  logic  busy;
  chan_t red_in_i;
  chan_t green_in_i;
  chan_t blue_in_i;
  logic  done_o;
  logic [HUE_W-1:0] hue_out_o;
  chan_t sat_out_o;
  chan_t value_out_o;

  hsv_t        pending_hsv[$];
  int unsigned error_count;
  int unsigned cycle_count;

  rgb_to_hsv_pixel_core #(
    .CHANNEL_BITS      (CHANNEL_BITS),
    .HUE_FRACTION_BITS (HUE_FRACTION_BITS)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .red_in_i    (red_in_i),
    .green_in_i  (green_in_i),
    .blue_in_i   (blue_in_i),
    .done_o      (done_o),
    .hue_out_o   (hue_out_o),
    .sat_out_o   (sat_out_o),
    .value_out_o (value_out_o)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Expected HSV of one pixel, exact integer form of the hue division
  function automatic hsv_t predict_hsv(chan_t r, chan_t g, chan_t b);
    hsv_t           res;
    longint         mx, mn, d, num, hue;
    min_sel_e       min_ch;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    res = '0;
    res.value_ch = chan_t'(mx);
    if (d != 0) begin
      // red takes a tied minimum over green, green over blue
      if (r == mn) min_ch = MIN_RED;
      else if (g == mn) min_ch = MIN_GREEN;
      else min_ch = MIN_BLUE;
      case (min_ch)
        MIN_RED:   num = SECTOR_RED * d + b - g;
        MIN_GREEN: num = SECTOR_GREEN * d + r - b;
        default:   num = SECTOR_BLUE * d + g - r;
      endcase
      hue = ((num * HUE_SCALE) << HUE_FRACTION_BITS) / d;
      // exactly one full turn wraps to zero
      if (hue >= (longint'(TURN_DEG) << HUE_FRACTION_BITS))
        hue -= longint'(TURN_DEG) << HUE_FRACTION_BITS;
      res.hue = hue[HUE_W-1:0];
      res.sat = chan_t'((longint'(CH_MAX) * d) / mx);
    end
    return res;
  endfunction

  // Idle length: mostly none, some short, a few long
  function automatic int pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Drive one pixel, wait for acceptance, log its expected result
  task automatic send_pixel(input chan_t r, input chan_t g, input chan_t b,
                            input int gap);
    @(negedge clk_i);
    start      <= 1'b1;
    red_in_i   <= r;
    green_in_i <= g;
    blue_in_i  <= b;
    do @(posedge clk_i); while (busy);
    pending_hsv.push_back(predict_hsv(r, g, b));
    // junk on the data lines while idle
    repeat (gap) begin
      @(negedge clk_i);
      start      <= 1'b0;
      red_in_i   <= chan_t'($urandom);
      green_in_i <= chan_t'($urandom);
      blue_in_i  <= chan_t'($urandom);
    end
  endtask

  task automatic report_field(input string field, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, act_v);
      error_count++;
    end
  endtask

  // Result checker
  always @(posedge clk_i) begin
    hsv_t exp_hsv;
    if (rst_ni && done_o) begin
      if (pending_hsv.size() == 0) begin
        $display("%0t: unexpected result, expected none, got hue %0d sat %0d value %0d",
                 $time, hue_out_o, sat_out_o, value_out_o);
        error_count++;
      end else begin
        exp_hsv = pending_hsv.pop_front();
        report_field("hue", exp_hsv.hue, hue_out_o);
        report_field("sat", exp_hsv.sat, sat_out_o);
        report_field("value", exp_hsv.value_ch, value_out_o);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Primaries, secondaries, greys and range extremes
  task automatic test_extremes();
    send_pixel(CH_MAX, 8'd0, 8'd0, 0);
    send_pixel(8'd0, CH_MAX, 8'd0, 0);
    send_pixel(8'd0, 8'd0, CH_MAX, 1);
    send_pixel(CH_MAX, CH_MAX, 8'd0, 0);
    send_pixel(8'd0, CH_MAX, CH_MAX, 2);
    send_pixel(CH_MAX, 8'd0, CH_MAX, 0);
    send_pixel(8'd0, 8'd0, 8'd0, 0);
    send_pixel(CH_MAX, CH_MAX, CH_MAX, 3);
    send_pixel(8'd128, 8'd128, 8'd128, 0);
    send_pixel(8'd1, 8'd0, 8'd0, 0);
    send_pixel(CH_MAX, 8'd254, 8'd254, 1);
  endtask

  // Tied minimum channels
  task automatic test_minimum_ties();
    send_pixel(8'd10, 8'd10, 8'd200, 0);
    send_pixel(8'd10, 8'd200, 8'd10, 0);
    send_pixel(8'd200, 8'd10, 8'd10, 2);
    send_pixel(8'd0, 8'd0, 8'd1, 0);
    send_pixel(8'd1, 8'd0, 8'd1, 0);
    send_pixel(8'd0, 8'd1, 8'd0, 5);
  endtask

  // Hues at and just below one full turn
  task automatic test_full_circle_wrap();
    send_pixel(CH_MAX, 8'd0, 8'd1, 0);
    send_pixel(8'd77, 8'd3, 8'd3, 0);
    send_pixel(CH_MAX, 8'd254, CH_MAX, 0);
    send_pixel(8'd2, 8'd1, 8'd1, 4);
    send_pixel(CH_MAX, 8'd0, 8'd254, 0);
  endtask

  // Random pixels, shaped towards greys, ties, small spreads and the wrap
  task automatic test_random_pixels();
    chan_t       r, g, b, lo, hi;
    int unsigned kind;
    bit          burst;
    burst = 0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 100 == 0) burst = ($urandom_range(0, 2) == 0);
      lo   = chan_t'($urandom);
      hi   = chan_t'($urandom);
      r    = chan_t'($urandom);
      g    = chan_t'($urandom);
      b    = chan_t'($urandom);
      kind = $urandom_range(0, 9);
      case (kind)
        5: begin
          g = r;
          b = r;
        end
        6: begin
          case ($urandom_range(0, 2))
            0: g = r;
            1: b = g;
            default: b = r;
          endcase
        end
        7: begin
          r = ($urandom_range(0, 2) == 0) ? 8'd0 : (($urandom_range(0, 1) == 0) ? CH_MAX : r);
          g = ($urandom_range(0, 2) == 0) ? 8'd0 : (($urandom_range(0, 1) == 0) ? CH_MAX : g);
          b = ($urandom_range(0, 2) == 0) ? 8'd0 : (($urandom_range(0, 1) == 0) ? CH_MAX : b);
        end
        8: begin
          g = (r > CH_MAX - 2) ? r - chan_t'($urandom_range(0, 2))
                               : r + chan_t'($urandom_range(0, 2));
          b = (r > CH_MAX - 2) ? r - chan_t'($urandom_range(0, 2))
                               : r + chan_t'($urandom_range(0, 2));
        end
        9: begin
          // red largest, green smallest, blue just above green
          if (lo > hi) begin
            r = lo;
            g = hi;
          end else begin
            r = hi;
            g = lo;
          end
          b = (r - g > 2) ? g + chan_t'($urandom_range(0, 2)) : g;
        end
        default: ;
      endcase
      send_pixel(r, g, b, burst ? 0 : pick_gap());
    end
  endtask

  initial begin
    error_count = 0;
    cycle_count = 0;
    rst_ni      = 1'b0;
    start       = 1'b0;
    red_in_i    = '0;
    green_in_i  = '0;
    blue_in_i   = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_extremes();
    test_minimum_ties();
    test_full_circle_wrap();
    test_random_pixels();

    @(negedge clk_i);
    start <= 1'b0;
    while (pending_hsv.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== rgb_to_hsv_pixel_core.f =====
sv/rgbhsv_pkg.sv
sv/rgbhsv_front.sv
sv/rgbhsv_div_step.sv
sv/rgb_to_hsv_pixel_core.sv
sv/rgbhsv_checker.sv
tb/testbench.sv
